/* sv/lrim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrim_pkg
// Shared types, sizes and constant tables for the long-range Ising flip block.
// ----------------------------------------------------------------------------
package lrim_pkg;

   localparam int SITES    = 256;
   localparam int SITE_W   = $clog2(SITES);
   localparam int HALF     = SITES / 2;
   localparam int DIST_W   = $clog2(HALF + 1);
   localparam int COUP_W   = 15;
   localparam int GRID_TOP = 8192;
   localparam int GRID_W   = $clog2(GRID_TOP + 1);
   localparam int FLOOR_W  = 17;
   localparam int MUL_W    = 32;
   localparam int ACC_W    = 64;
   localparam int DE_W     = 20;
   localparam int EN_W     = 41;
   localparam int MG_W     = 10;
   localparam int FIELD_W  = 16;
   localparam int BETA_W   = 16;
   localparam int UNI_W    = 16;
   localparam int BETA_RST = 256;
   localparam int STEP_W   = 3;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_FLIP   = 2'd1;

   // exp(-1/256) in Q0.62, series to the eighth power, each term truncated
   localparam logic [63:0] EXP_T0 = 64'd1 << 62;
   localparam logic [63:0] EXP_T1 = EXP_T0 / 64'd256;
   localparam logic [63:0] EXP_T2 = EXP_T1 / 64'd512;
   localparam logic [63:0] EXP_T3 = EXP_T2 / 64'd768;
   localparam logic [63:0] EXP_T4 = EXP_T3 / 64'd1024;
   localparam logic [63:0] EXP_T5 = EXP_T4 / 64'd1280;
   localparam logic [63:0] EXP_T6 = EXP_T5 / 64'd1536;
   localparam logic [63:0] EXP_T7 = EXP_T6 / 64'd1792;
   localparam logic [63:0] EXP_T8 = EXP_T7 / 64'd2048;

   localparam logic [63:0] EXP_STEP = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                      - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8;

   typedef logic [HALF:0][COUP_W-1:0] coup_tab_type;

   // 16384 over d squared, halves rounded up, by long division; zero at distance zero
   function automatic coup_tab_type build_coupling();
      coup_tab_type t;
      int unsigned  dd;
      int unsigned  num;
      int unsigned  quo;
      for (int d = 0; d <= HALF; d++) begin
         dd   = d * d;
         t[d] = '0;
         if (dd != 0) begin
            num = 32768 + dd;
            quo = 0;
            for (int b = COUP_W - 1; b >= 0; b--) begin
               if (((2 * dd) << b) <= num) begin
                  num = num - ((2 * dd) << b);
                  quo = quo | (32'd1 << b);
               end
            end
            t[d] = COUP_W'(quo);
         end
      end
      return t;
   endfunction

   localparam coup_tab_type COUPLING = build_coupling();

   typedef enum logic [2:0] {
      MAC_IDLE = 3'd0,
      MAC_SET  = 3'd1,
      MAC_NSET = 3'd2,
      MAC_ADD  = 3'd3,
      MAC_SUB  = 3'd4,
      MAC_SHR  = 3'd5
   } mac_op_type;

   typedef struct packed {
      mac_op_type       op;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mac_cmd_type;

endpackage

/* sv/lrim_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrim_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lrim_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrim_mac
// Shared 32x32 multiply-accumulate unit with a 64-bit accumulator.
// ----------------------------------------------------------------------------
module lrim_mac (
   input  logic                         clock,
   input  lrim_pkg::mac_cmd_type        cmd,
   output logic [lrim_pkg::ACC_W-1:0]   acc
);

   logic [lrim_pkg::ACC_W-1:0] acc_ff;
   logic [lrim_pkg::ACC_W-1:0] acc_in;
   logic [lrim_pkg::ACC_W-1:0] prod;

   assign prod = lrim_pkg::ACC_W'(cmd.a) * lrim_pkg::ACC_W'(cmd.b);

   always_comb begin
      case (cmd.op)
         lrim_pkg::MAC_SET:  acc_in = prod;
         lrim_pkg::MAC_NSET: acc_in = '0 - prod;
         lrim_pkg::MAC_ADD:  acc_in = acc_ff + prod;
         lrim_pkg::MAC_SUB:  acc_in = acc_ff - prod;
         lrim_pkg::MAC_SHR:  acc_in = acc_ff >> 31;
         default:            acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* sv/long_range_ising_metropolis_flip.sv */
`timescale 1ns / 1ps
// Throughput: one item at a time; the coupling sum runs one site per cycle through the MAC.
// Reset: synchronous; afterwards the acceptance table is built over 8,193 grid points,
// each by 31-bit half products through the shared MAC; no request beat until then.
// Spins reset to +1, energy to zero, magnetisation to SITES, beta to 1.0; the spin and
// field stores are cleared during the first SITES grid points of that build.
// ----------------------------------------------------------------------------
// long_range_ising_metropolis_flip
// Metropolis single-spin update on a ring with inverse-square coupling, one shared MAC.
// ----------------------------------------------------------------------------
module long_range_ising_metropolis_flip (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [7:0]                          req_site,
   input  logic signed [15:0]                  req_field_value,
   input  logic [15:0]                         req_uniform,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic signed [19:0]                  rsp_delta_energy,
   output logic signed [40:0]                  rsp_total_energy,
   output logic signed [9:0]                   rsp_magnet_sum,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [15:0]                         csr_inverse_temperature
);

   localparam int SW = lrim_pkg::SITE_W;

   typedef enum logic [11:0] {
      ST_INIT  = 12'b0000_0000_0001,
      ST_IDLE  = 12'b0000_0000_0010,
      ST_FETCH = 12'b0000_0000_0100,
      ST_LOAD  = 12'b0000_0000_1000,
      ST_SEED  = 12'b0000_0001_0000,
      ST_SUM   = 12'b0000_0010_0000,
      ST_DE    = 12'b0000_0100_0000,
      ST_MUL   = 12'b0000_1000_0000,
      ST_KIDX  = 12'b0001_0000_0000,
      ST_TCMP  = 12'b0010_0000_0000,
      ST_APPLY = 12'b0100_0000_0000,
      ST_RESP  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // table build
   logic [lrim_pkg::STEP_W-1:0]    gen_step_ff, gen_step_in;
   logic [lrim_pkg::GRID_W-1:0]    gen_k_ff, gen_k_in;
   logic [62:0]                    r_ff, r_in;

   // configuration and latched request
   logic [lrim_pkg::BETA_W-1:0]    beta_ff, beta_in;
   logic [1:0]                     kind_ff, kind_in;
   logic [SW-1:0]                  site_ff, site_in;
   logic [lrim_pkg::FIELD_W-1:0]   field_ff, field_in;
   logic [lrim_pkg::UNI_W-1:0]     uniform_ff, uniform_in;

   // sweep
   logic [SW:0]                    j_ff, j_in;
   logic [SW-1:0]                  jp_ff, jp_in;
   logic                           own_ff, own_in;

   // result and system state
   logic [lrim_pkg::DE_W-1:0]      de_ff, de_in;
   logic                           acc_flag_ff, acc_flag_in;
   logic [lrim_pkg::EN_W-1:0]      energy_ff, energy_in;
   logic [lrim_pkg::MG_W-1:0]      magnet_ff, magnet_in;

   // memories
   logic                           clear_go;
   logic                           spin_wr_en;
   logic [SW-1:0]                  spin_wr_addr;
   logic                           spin_wr_data;
   logic [SW-1:0]                  spin_rd_addr;
   logic                           spin_q;
   logic                           spin_bit;
   logic                           field_wr_en;
   logic [SW-1:0]                  field_wr_addr;
   logic [lrim_pkg::FIELD_W-1:0]   field_wr_data;
   logic [lrim_pkg::FIELD_W-1:0]   field_q;
   logic                           tab_wr_en;
   logic [lrim_pkg::GRID_W-1:0]    tab_rd_addr;
   logic [lrim_pkg::FLOOR_W-1:0]   floor_q;

   lrim_pkg::mac_cmd_type          mac_cmd;
   logic [lrim_pkg::ACC_W-1:0]     mac_acc;

   // combinational helpers
   logic [SW-1:0]                  dist_diff;
   logic [SW:0]                    dist_r, dist_c;
   logic [lrim_pkg::DIST_W-1:0]    ring_dist;
   logic [16:0]                    h_ext, h_mag;
   logic [16:0]                    ld_diff;
   logic [18:0]                    ld_delta;
   logic [lrim_pkg::DE_W-1:0]      de_dbl;

   lrim_mac u_mac (
      .clock (clock),
      .cmd   (mac_cmd),
      .acc   (mac_acc)
   );

   lrim_ram #(.WIDTH(1), .DEPTH(lrim_pkg::SITES)) u_spin_ram (
      .clock   (clock),
      .wr_en   (spin_wr_en),
      .wr_addr (spin_wr_addr),
      .wr_data (spin_wr_data),
      .rd_addr (spin_rd_addr),
      .rd_data (spin_q)
   );

   lrim_ram #(.WIDTH(lrim_pkg::FIELD_W), .DEPTH(lrim_pkg::SITES)) u_field_ram (
      .clock   (clock),
      .wr_en   (field_wr_en),
      .wr_addr (field_wr_addr),
      .wr_data (field_wr_data),
      .rd_addr (site_ff),
      .rd_data (field_q)
   );

   lrim_ram #(.WIDTH(lrim_pkg::FLOOR_W), .DEPTH(lrim_pkg::GRID_TOP + 1)) u_floor_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (gen_k_ff),
      .wr_data (r_ff[62:46]),
      .rd_addr (tab_rd_addr),
      .rd_data (floor_q)
   );

   // Clear spins to +1 and fields to zero while the first SITES grid points are built.
   assign clear_go      = (state_ff == ST_INIT)
                          && (gen_k_ff < lrim_pkg::GRID_W'(lrim_pkg::SITES));
   assign spin_wr_addr  = clear_go ? gen_k_ff[SW-1:0] : site_ff;
   assign spin_wr_data  = clear_go ? 1'b1 : ~own_ff;
   assign field_wr_addr = clear_go ? gen_k_ff[SW-1:0] : site_ff;
   assign field_wr_data = clear_go ? '0 : field_ff;

   assign spin_bit = spin_q;

   // Ring distance between the swept site and the target site.
   always_comb begin
      dist_diff = (jp_ff > site_ff) ? (jp_ff - site_ff) : (site_ff - jp_ff);
      dist_r    = {1'b0, dist_diff};
      dist_c    = (SW + 1)'(lrim_pkg::SITES) - dist_r;
      ring_dist = (dist_r < dist_c) ? lrim_pkg::DIST_W'(dist_r)
                                    : lrim_pkg::DIST_W'(dist_c);
   end

   // Magnitude of the stored field, for the seed of the local sum.
   assign h_ext = {field_q[15], field_q};
   assign h_mag = h_ext[16] ? (17'd0 - h_ext) : h_ext;

   // Load: 4*(h_old - h_new), sign by the current spin.
   always_comb begin
      ld_diff  = {field_q[15], field_q} - {field_ff[15], field_ff};
      ld_delta = spin_bit ? {ld_diff, 2'b00} : (19'd0 - {ld_diff, 2'b00});
   end

   // dE = 2 * s_i * local; the local sum fits in 19 bits.
   assign de_dbl = {mac_acc[18:0], 1'b0};

   // Grid index for the table: (beta*dE) >> 14, clamp at the top.
   assign tab_rd_addr = (mac_acc[lrim_pkg::ACC_W-1:14] > (lrim_pkg::ACC_W - 14)'(lrim_pkg::GRID_TOP))
                        ? lrim_pkg::GRID_W'(lrim_pkg::GRID_TOP)
                        : mac_acc[14 +: lrim_pkg::GRID_W];

   always_comb begin
      case (state_ff)
         ST_FETCH: spin_rd_addr = site_ff;
         ST_SEED:  spin_rd_addr = '0;
         ST_SUM:   spin_rd_addr = j_ff[SW-1:0];
         default:  spin_rd_addr = site_ff;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign csr_ready = 1'b1;

   assign rsp_accepted     = acc_flag_ff;
   assign rsp_delta_energy = $signed(de_ff);
   assign rsp_total_energy = $signed(energy_ff);
   assign rsp_magnet_sum   = $signed(magnet_ff);

   always_comb begin
      state_in    = state_ff;
      gen_step_in = gen_step_ff;
      gen_k_in    = gen_k_ff;
      r_in        = r_ff;
      beta_in     = beta_ff;
      kind_in     = kind_ff;
      site_in     = site_ff;
      field_in    = field_ff;
      uniform_in  = uniform_ff;
      j_in        = j_ff;
      jp_in       = jp_ff;
      own_in      = own_ff;
      de_in       = de_ff;
      acc_flag_in = acc_flag_ff;
      energy_in   = energy_ff;
      magnet_in   = magnet_ff;
      spin_wr_en  = 1'b0;
      field_wr_en = 1'b0;
      tab_wr_en   = 1'b0;
      mac_cmd.op  = lrim_pkg::MAC_IDLE;
      mac_cmd.a   = '0;
      mac_cmd.b   = '0;

      if (csr_valid && csr_ready) begin
         beta_in = csr_inverse_temperature;
      end

      case (state_ff)
         ST_INIT: begin
            spin_wr_en  = clear_go;
            field_wr_en = clear_go;
            // r(k+1) = (r(k) * E) >> 62 in 31-bit halves
            gen_step_in = gen_step_ff + 1'b1;
            case (gen_step_ff)
               3'd0: begin
                  tab_wr_en  = 1'b1;
                  mac_cmd.op = lrim_pkg::MAC_SET;
                  mac_cmd.a  = lrim_pkg::MUL_W'(r_ff[30:0]);
                  mac_cmd.b  = lrim_pkg::MUL_W'(lrim_pkg::EXP_STEP[30:0]);
                  if (gen_k_ff == lrim_pkg::GRID_W'(lrim_pkg::GRID_TOP)) begin
                     state_in = ST_IDLE;
                  end
               end
               3'd1: mac_cmd.op = lrim_pkg::MAC_SHR;
               3'd2: begin
                  mac_cmd.op = lrim_pkg::MAC_ADD;
                  mac_cmd.a  = r_ff[62:31];
                  mac_cmd.b  = lrim_pkg::MUL_W'(lrim_pkg::EXP_STEP[30:0]);
               end
               3'd3: begin
                  mac_cmd.op = lrim_pkg::MAC_ADD;
                  mac_cmd.a  = lrim_pkg::MUL_W'(r_ff[30:0]);
                  mac_cmd.b  = lrim_pkg::MUL_W'(lrim_pkg::EXP_STEP[61:31]);
               end
               3'd4: mac_cmd.op = lrim_pkg::MAC_SHR;
               3'd5: begin
                  mac_cmd.op = lrim_pkg::MAC_ADD;
                  mac_cmd.a  = r_ff[62:31];
                  mac_cmd.b  = lrim_pkg::MUL_W'(lrim_pkg::EXP_STEP[61:31]);
               end
               default: begin
                  r_in        = mac_acc[62:0];
                  gen_k_in    = gen_k_ff + 1'b1;
                  gen_step_in = '0;
               end
            endcase
         end

         ST_IDLE: begin
            if (req_valid) begin
               kind_in     = req_type;
               site_in     = req_site;
               field_in    = req_field_value;
               uniform_in  = req_uniform;
               de_in       = '0;
               acc_flag_in = 1'b0;
               if ((req_type == lrim_pkg::REQ_LOAD || req_type == lrim_pkg::REQ_FLIP)
                   && (int'(req_site) < lrim_pkg::SITES)) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_FETCH: begin
            state_in = (kind_ff == lrim_pkg::REQ_LOAD) ? ST_LOAD : ST_SEED;
         end

         ST_LOAD: begin
            field_wr_en = 1'b1;
            energy_in   = energy_ff + {{(lrim_pkg::EN_W - 19){ld_delta[18]}}, ld_delta};
            state_in    = ST_RESP;
         end

         ST_SEED: begin
            // seed the local sum with 4*h
            mac_cmd.op = h_ext[16] ? lrim_pkg::MAC_NSET : lrim_pkg::MAC_SET;
            mac_cmd.a  = lrim_pkg::MUL_W'(h_mag);
            mac_cmd.b  = lrim_pkg::MUL_W'(4);
            j_in       = (SW + 1)'(1);
            jp_in      = '0;
            state_in   = ST_SUM;
         end

         ST_SUM: begin
            if (jp_ff == site_ff) begin
               own_in = spin_bit;
            end else begin
               mac_cmd.op = spin_bit ? lrim_pkg::MAC_ADD : lrim_pkg::MAC_SUB;
               mac_cmd.a  = lrim_pkg::MUL_W'(lrim_pkg::COUPLING[ring_dist]);
               mac_cmd.b  = lrim_pkg::MUL_W'(1);
            end
            jp_in = j_ff[SW-1:0];
            j_in  = j_ff + 1'b1;
            if (int'(jp_ff) == lrim_pkg::SITES - 1) begin
               state_in = ST_DE;
            end
         end

         ST_DE: begin
            de_in = own_ff ? de_dbl : (lrim_pkg::DE_W'(0) - de_dbl);
            if (own_ff ? (de_dbl[19] || de_dbl == '0)
                       : (!de_dbl[19] || de_dbl == '0)) begin
               acc_flag_in = 1'b1;
               state_in    = ST_APPLY;
            end else begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            mac_cmd.op = lrim_pkg::MAC_SET;
            mac_cmd.a  = lrim_pkg::MUL_W'(beta_ff);
            mac_cmd.b  = lrim_pkg::MUL_W'(de_ff);
            state_in   = ST_KIDX;
         end

         ST_KIDX: begin
            state_in = ST_TCMP;
         end

         ST_TCMP: begin
            if (lrim_pkg::FLOOR_W'(uniform_ff) < floor_q) begin
               acc_flag_in = 1'b1;
               state_in    = ST_APPLY;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_APPLY: begin
            spin_wr_en = 1'b1;
            energy_in  = energy_ff + {{(lrim_pkg::EN_W - lrim_pkg::DE_W){de_ff[19]}}, de_ff};
            magnet_in  = own_ff ? (magnet_ff - lrim_pkg::MG_W'(2))
                                : (magnet_ff + lrim_pkg::MG_W'(2));
            state_in   = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         gen_step_ff <= '0;
         gen_k_ff    <= '0;
         r_ff        <= 63'd1 << 62;
         beta_ff     <= lrim_pkg::BETA_W'(lrim_pkg::BETA_RST);
         energy_ff   <= '0;
         magnet_ff   <= lrim_pkg::MG_W'(lrim_pkg::SITES);
         acc_flag_ff <= 1'b0;
         de_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         gen_step_ff <= gen_step_in;
         gen_k_ff    <= gen_k_in;
         r_ff        <= r_in;
         beta_ff     <= beta_in;
         energy_ff   <= energy_in;
         magnet_ff   <= magnet_in;
         acc_flag_ff <= acc_flag_in;
         de_ff       <= de_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      site_ff    <= site_in;
      field_ff   <= field_in;
      uniform_ff <= uniform_in;
      j_ff       <= j_in;
      jp_ff      <= jp_in;
      own_ff     <= own_in;
   end

endmodule

/* dv/ising_flip_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_flip_checker
// Watches the request, response and CSR channels of the long-range Ising flip
// block. It keeps its own copy of the spin ring and predicts each response.
// ----------------------------------------------------------------------------
module ising_flip_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_site,
   input  logic signed [15:0] req_field_value,
   input  logic [15:0]        req_uniform,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_accepted,
   input  logic signed [19:0] rsp_delta_energy,
   input  logic signed [40:0] rsp_total_energy,
   input  logic signed [9:0]  rsp_magnet_sum,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [15:0]        csr_inverse_temperature,
   output int                 fail_count,
   output int                 outstanding
);

   typedef struct {
      logic               accepted;
      logic signed [19:0] delta_energy;
      logic signed [40:0] total_energy;
      logic signed [9:0]  magnet_sum;
   } flip_outcome_type;

   flip_outcome_type   outcome_q[$];
   int                 coup_by_dist[0:lrim_pkg::SITES/2];
   int unsigned        accept_floor[0:lrim_pkg::GRID_TOP];
   bit                 spin_up[lrim_pkg::SITES];
   logic signed [15:0] site_field[lrim_pkg::SITES];
   logic signed [40:0] energy;
   logic signed [9:0]  magnet;
   logic [15:0]        beta;

   // (a*b) >> 62 from 31-bit halves, low partial products truncated
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [63:0] ah;
      logic [63:0] al;
      logic [63:0] bh;
      logic [63:0] bl;
      logic [63:0] mid;
      ah  = a >> 31;
      al  = a & 64'h7FFF_FFFF;
      bh  = b >> 31;
      bl  = b & 64'h7FFF_FFFF;
      mid = ah * bl + al * bh + ((al * bl) >> 31);
      return ah * bh + (mid >> 31);
   endfunction

   // couplings round(16384/d^2) and the floor(65536*exp(-k/256)) table
   initial begin
      logic [63:0]  term;
      logic [63:0]  e_step;
      logic [63:0]  r;
      int unsigned  dd;
      for (int d = 0; d <= lrim_pkg::SITES / 2; d++) begin
         dd = d * d;
         coup_by_dist[d] = (dd == 0) ? 0 : int'((32768 + dd) / (2 * dd));
      end
      term   = 64'd1 << 62;
      e_step = term;
      for (int n = 1; n <= 8; n++) begin
         term = term / (64'd256 * n);
         e_step = (n % 2 == 1) ? e_step - term : e_step + term;
      end
      r = 64'd1 << 62;
      for (int k = 0; k <= lrim_pkg::GRID_TOP; k++) begin
         accept_floor[k] = int'(r >> 46);
         r = mul_q62(r, e_step);
      end
   end

   function automatic flip_outcome_type metropolis_step(logic [1:0] kind, int s,
                                                        logic signed [15:0] h_new,
                                                        int unsigned u);
      flip_outcome_type o;
      int               sg;
      int               local_sum;
      int               ring_d;
      int               de;
      longint           k;
      o.accepted = 0;
      de = 0;
      if (kind == lrim_pkg::REQ_LOAD && s < lrim_pkg::SITES) begin
         sg = spin_up[s] ? 1 : -1;
         energy += 41'(longint'((int'(site_field[s]) - int'(h_new)) * 4 * sg));
         site_field[s] = h_new;
      end else if (kind == lrim_pkg::REQ_FLIP && s < lrim_pkg::SITES) begin
         sg = spin_up[s] ? 1 : -1;
         local_sum = int'(site_field[s]) * 4;
         for (int j = 0; j < lrim_pkg::SITES; j++) begin
            if (j != s) begin
               ring_d = (j > s) ? j - s : s - j;
               if (lrim_pkg::SITES - ring_d < ring_d) ring_d = lrim_pkg::SITES - ring_d;
               local_sum += spin_up[j] ? coup_by_dist[ring_d] : -coup_by_dist[ring_d];
            end
         end
         de = 2 * sg * local_sum;
         if (de <= 0) begin
            o.accepted = 1;
         end else begin
            k = (longint'(beta) * longint'(de)) >>> 14;
            if (k > lrim_pkg::GRID_TOP) k = lrim_pkg::GRID_TOP;
            o.accepted = (u < accept_floor[k]);
         end
         if (o.accepted) begin
            spin_up[s] = !spin_up[s];
            energy += 41'(longint'(de));
            magnet -= 10'(2 * sg);
         end
      end
      o.delta_energy = 20'(de);
      o.total_energy = energy;
      o.magnet_sum   = magnet;
      return o;
   endfunction

   task automatic flag_mismatch(string what, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      flip_outcome_type want;
      if (reset) begin
         for (int i = 0; i < lrim_pkg::SITES; i++) begin
            spin_up[i]    = 1;
            site_field[i] = '0;
         end
         energy     = '0;
         magnet     = 10'(lrim_pkg::SITES);
         beta       = 16'(lrim_pkg::BETA_RST);
         fail_count = 0;
         outcome_q.delete();
      end else begin
         // retire the response beat first, then predict the request beat
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               flag_mismatch("unexpected response", 0, 0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_accepted !== want.accepted)
                  flag_mismatch("accepted", rsp_accepted, want.accepted);
               if (rsp_delta_energy !== want.delta_energy)
                  flag_mismatch("delta_energy", rsp_delta_energy, want.delta_energy);
               if (rsp_total_energy !== want.total_energy)
                  flag_mismatch("total_energy", rsp_total_energy, want.total_energy);
               if (rsp_magnet_sum !== want.magnet_sum)
                  flag_mismatch("magnet_sum", rsp_magnet_sum, want.magnet_sum);
            end
         end
         if (csr_valid && csr_ready) beta = csr_inverse_temperature;
         if (req_valid && req_ready)
            outcome_q = {outcome_q, metropolis_step(req_type, int'(req_site),
                                                    req_field_value, int'(req_uniform))};
      end
      outstanding <= outcome_q.size();
   end

endmodule

/* dv/long_range_ising_metropolis_flip_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// long_range_ising_metropolis_flip_test
// Drives loads, flip attempts and status reads into the Ising flip block over
// several inverse temperatures; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module long_range_ising_metropolis_flip_test;

   localparam logic [1:0] REQ_STATUS = 2'd2;
   localparam logic [1:0] REQ_STATUS_ALT = 2'd3;
   localparam int RANDOM_ITEMS = 1180;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 2500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_type;
   logic [7:0]         req_site;
   logic signed [15:0] req_field_value;
   logic [15:0]        req_uniform;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_accepted;
   logic signed [19:0] rsp_delta_energy;
   logic signed [40:0] rsp_total_energy;
   logic signed [9:0]  rsp_magnet_sum;
   logic               csr_valid;
   logic               csr_ready;
   logic [15:0]        csr_inverse_temperature;

   int  fail_count;
   int  outstanding;
   int  cycle_count = 0;
   int  hold_left;
   bit  calm;
   bit  hold_req;
   bit  hold_seen;
   bit  site_loaded[lrim_pkg::SITES];
   int  loaded_count;

   long_range_ising_metropolis_flip dut (.*);

   ising_flip_checker u_checker (.*);

   always #1 clock = ~clock;

   // watchdog: give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("long_range_ising_metropolis_flip_test: FAIL");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else begin
         hold_seen <= hold_req;
         if (hold_req && !hold_seen) begin
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 12);
         end
      end
   end

   // send one beat; hold valid and payload until taken, idle now and then after
   task automatic send_beat(logic [1:0] kind, logic [7:0] s,
                            logic [15:0] h, logic [15:0] u);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_site        <= s;
      req_field_value <= h;
      req_uniform     <= u;
      if (kind == lrim_pkg::REQ_LOAD) begin
         if (!site_loaded[s]) loaded_count++;
         site_loaded[s] = 1;
      end
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic drop_valid_and_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // every request is answered, so the block is idle by now
      repeat (12) @(posedge clock);
   endtask

   task automatic write_beta(logic [15:0] b);
      drop_valid_and_drain();
      csr_valid <= 1'b1;
      csr_inverse_temperature <= b;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_loaded_site();
      logic [7:0] s;
      do s = 8'($urandom_range(lrim_pkg::SITES - 1)); while (!site_loaded[s]);
      return s;
   endfunction

   function automatic logic [15:0] pick_uniform();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_field();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int          roll;
      logic [15:0] beta_steps[6];
      req_valid = 1'b0;
      req_type = REQ_STATUS;
      req_site = '0;
      req_field_value = '0;
      req_uniform = '0;
      csr_valid = 1'b0;
      csr_inverse_temperature = '0;
      loaded_count = 0;
      calm = 0;
      hold_req = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, extreme fields, extreme uniforms, extreme betas
      send_beat(REQ_STATUS, 8'd0, 16'h0000, 16'h0000);
      send_beat(REQ_STATUS_ALT, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_beat(lrim_pkg::REQ_LOAD, 8'd0, 16'h7FFF, 16'h0000);
      send_beat(lrim_pkg::REQ_LOAD, 8'd255, 16'h8000, 16'hFFFF);
      send_beat(lrim_pkg::REQ_LOAD, 8'd128, 16'h0000, 16'h0000);
      send_beat(lrim_pkg::REQ_LOAD, 8'd1, 16'h0001, 16'h0000);
      send_beat(lrim_pkg::REQ_FLIP, 8'd0, 16'h0000, 16'h0000);
      send_beat(lrim_pkg::REQ_FLIP, 8'd255, 16'h0000, 16'hFFFF);
      send_beat(lrim_pkg::REQ_LOAD, 8'd255, 16'h04D2, 16'h0000);
      send_beat(lrim_pkg::REQ_FLIP, 8'd128, 16'h0000, 16'h0000);
      send_beat(lrim_pkg::REQ_FLIP, 8'd1, 16'h0000, 16'hFFFF);
      send_beat(lrim_pkg::REQ_FLIP, 8'd255, 16'hFFFF, 16'h0000);
      send_beat(REQ_STATUS, 8'd7, 16'h1234, 16'h0000);
      write_beta(16'h0000);
      send_beat(lrim_pkg::REQ_FLIP, 8'd0, 16'h0000, 16'hFFFF);
      send_beat(lrim_pkg::REQ_FLIP, 8'd128, 16'h0000, 16'hFFFF);
      write_beta(16'hFFFF);
      send_beat(lrim_pkg::REQ_FLIP, 8'd1, 16'h0000, 16'h0000);
      send_beat(lrim_pkg::REQ_FLIP, 8'd0, 16'h0000, 16'h0000);
      write_beta(16'h0001);
      send_beat(lrim_pkg::REQ_FLIP, 8'd1, 16'h0000, 16'hFFFE);

      // random phases over several betas; one calm phase, one long hold-off
      beta_steps = '{16'd256, 16'd64, 16'hFFFF, 16'd0, 16'd1, 16'($urandom)};
      for (int ph = 0; ph < 6; ph++) begin
         write_beta(beta_steps[ph]);
         calm = (ph == 2);
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            if (ph == 1 && n == 40) hold_req = 1;
            if (ph == 3 && n == 30) drop_valid_and_drain();
            roll = $urandom_range(99);
            if (roll < 8 || loaded_count == 0)
               send_beat(lrim_pkg::REQ_LOAD, 8'($urandom), pick_field(), 16'($urandom));
            else if (roll < 14)
               send_beat(2'($urandom_range(3, 2)), 8'($urandom), 16'($urandom),
                         16'($urandom));
            else
               send_beat(lrim_pkg::REQ_FLIP, pick_loaded_site(), 16'($urandom),
                         pick_uniform());
         end
         calm = 0;
      end

      drop_valid_and_drain();
      if (fail_count == 0) begin
         $display("long_range_ising_metropolis_flip_test: PASS");
      end else begin
         $display("long_range_ising_metropolis_flip_test: FAIL");
      end
      $finish;
   end

endmodule
